FILE: hdl/gc_victim_zone_selector_core_defines.svh
// Assertion macros for the GC victim zone selector.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef GC_VICTIM_ZONE_SELECTOR_CORE_DEFINES_SVH
`define GC_VICTIM_ZONE_SELECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define GVZS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define GVZS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GVZS_ASSERT(lbl, clk, rst_n, prop, msg)
`define GVZS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/gvzs_pkg.sv
// Shared types and constants for the GC victim zone selector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gvzs_pkg;

  localparam int unsigned ZoneW  = 12;
  localparam int unsigned CountW = 17;
  localparam int unsigned TsW    = 48;
  localparam int unsigned KeyW   = 48;
  localparam int unsigned HeatW  = CountW + 2;
  localparam int unsigned ModeW  = 2;

  // Encoding 3 is unused and falls back to greedy.
  typedef enum logic [ModeW-1:0] {
    MODE_GREEDY = 2'd0,
    MODE_TS     = 2'd1,
    MODE_HEAT   = 2'd2
  } mode_e;

  typedef struct packed {
    logic [ZoneW-1:0]  zone_index;
    logic              zone_full;
    logic [CountW-1:0] gc_blocks;
    logic [TsW-1:0]    age_sum;
    logic [CountW-1:0] before_count;
    logic [CountW-1:0] after_count;
    logic              last_zone;
  } zone_stat_t;

  typedef struct packed {
    logic              found;
    logic [ZoneW-1:0]  victim_zone;
    logic [CountW-1:0] victim_blocks;
  } victim_t;

  // Tracker to stage control: advance consumes the held item, emit loads a result.
  typedef struct packed {
    logic advance;
    logic emit;
  } trk_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/gc_victim_zone_selector_core.sv
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   in_data_i   (zone_stat_t)
// out      out_valid_o / out_ready_i out_data_o  (victim_t)
// cfg      cfg_valid_i / cfg_ready_o cfg_data_i  (select mode)
//
// One zone item per cycle; a last item moves from the input register to the result register.
// Throughput is set by the single compare of the tracker against the running best.
// A last item waits in the input register while the result register is still full.
// Reset clears the mode to greedy, the running best and both stage valids.
//
// Top level of the GC victim zone selector; depends on gvzs_pkg, the stage modules
// and gc_victim_zone_selector_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "gc_victim_zone_selector_core_defines.svh"

module gc_victim_zone_selector_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  gvzs_pkg::zone_stat_t           in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output gvzs_pkg::victim_t              out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [gvzs_pkg::ModeW-1:0]      cfg_data_i
);
  import gvzs_pkg::*;

  mode_e      mode_q;
  logic       item_valid;
  zone_stat_t item;
  trk_ctl_t   ctl;
  victim_t    result;
  logic       out_free;
  logic       best_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GREEDY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  gvzs_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .ctl_i        (ctl),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  gvzs_best_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .ctl_o        (ctl),
    .result_o     (result),
    .best_valid_o (best_valid)
  );

  gvzs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A held last item must not be dropped while the result slot is busy.
  `GVZS_ASSERT(a_last_held, clk_i, rst_ni, item_valid && item.last_zone && out_valid_o && !out_ready_i |=> item_valid, "last item lost while output stalled")
  // A finished scan leaves no best zone behind.
  `GVZS_ASSERT(a_scan_clears, clk_i, rst_ni, ctl.emit |=> !best_valid, "best zone not cleared after report")
  // An empty report carries no zone or garbage count.
  `GVZS_ASSERT(a_empty_report, clk_i, rst_ni, out_valid_o && !out_data_o.found |-> out_data_o.victim_zone == '0 && out_data_o.victim_blocks == '0, "empty report has payload")
  // A result is only loaded into a free slot.
  `GVZS_ASSERT_ALWAYS(a_no_overwrite, clk_i, ctl.emit |-> out_free, "result register overwritten")

endmodule

`default_nettype wire

FILE: hdl/gvzs_in_stage.sv
// Input register for one zone statistics item.
// Depends on gvzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gvzs_in_stage (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  gvzs_pkg::zone_stat_t    in_data_i,
  input  gvzs_pkg::trk_ctl_t      ctl_i,
  output logic                    item_valid_o,
  output gvzs_pkg::zone_stat_t    item_o
);
  import gvzs_pkg::*;

  logic       vld_q, vld_d;
  zone_stat_t item_q;

  // Free when empty or when the held item leaves this cycle.
  assign in_ready_o = !vld_q || ctl_i.advance;

  always_comb begin
    vld_d = vld_q;
    if (in_ready_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: hdl/gvzs_best_tracker.sv
// Compare-and-keep-best logic with the running best zone of the scan.
// Depends on gvzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gvzs_best_tracker (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  gvzs_pkg::mode_e         mode_i,
  input  wire                     item_valid_i,
  input  gvzs_pkg::zone_stat_t    item_i,
  input  wire                     out_free_i,
  output gvzs_pkg::trk_ctl_t      ctl_o,
  output gvzs_pkg::victim_t       result_o,
  output logic                    best_valid_o
);
  import gvzs_pkg::*;

  logic              best_valid_q, best_valid_d;
  logic [ZoneW-1:0]  best_zone_q, best_zone_d;
  logic [KeyW-1:0]   best_key_q, best_key_d;
  logic [CountW-1:0] best_garbage_q, best_garbage_d;

  logic [HeatW-1:0]  heat;
  logic [KeyW-1:0]   key;
  logic              better;
  logic              take;

  logic              nb_valid;
  logic [ZoneW-1:0]  nb_zone;
  logic [KeyW-1:0]   nb_key;
  logic [CountW-1:0] nb_garbage;

  // A last item needs the result slot; others always move on.
  assign ctl_o.advance = item_valid_i && (!item_i.last_zone || out_free_i);
  assign ctl_o.emit    = ctl_o.advance && item_i.last_zone;

  assign heat = {2'b00, item_i.before_count} + {1'b0, item_i.after_count, 1'b0};

  always_comb begin
    unique case (mode_i)
      MODE_TS: begin
        key    = item_i.age_sum;
        better = key < best_key_q;
      end
      MODE_HEAT: begin
        key    = {{(KeyW-HeatW){1'b0}}, heat};
        better = key < best_key_q;
      end
      default: begin
        key    = {{(KeyW-CountW){1'b0}}, item_i.gc_blocks};
        better = key > best_key_q;
      end
    endcase
  end

  // Strict compares keep the earlier zone on a tie.
  assign take = item_i.zone_full && (!best_valid_q || better);

  always_comb begin
    nb_valid   = best_valid_q || take;
    nb_zone    = take ? item_i.zone_index : best_zone_q;
    nb_key     = take ? key               : best_key_q;
    nb_garbage = take ? item_i.gc_blocks  : best_garbage_q;
  end

  always_comb begin
    best_valid_d   = best_valid_q;
    best_zone_d    = best_zone_q;
    best_key_d     = best_key_q;
    best_garbage_d = best_garbage_q;
    if (ctl_o.advance) begin
      best_valid_d   = nb_valid && !item_i.last_zone;
      best_zone_d    = nb_zone;
      best_key_d     = nb_key;
      best_garbage_d = nb_garbage;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
    end else begin
      best_valid_q <= best_valid_d;
    end
  end

  // Payload only matters while best_valid_q is set.
  always_ff @(posedge clk_i) begin
    best_zone_q    <= best_zone_d;
    best_key_q     <= best_key_d;
    best_garbage_q <= best_garbage_d;
  end

  assign result_o.found         = nb_valid;
  assign result_o.victim_zone   = nb_valid ? nb_zone : '0;
  assign result_o.victim_blocks = nb_valid ? nb_garbage : '0;
  assign best_valid_o           = best_valid_q;

endmodule

`default_nettype wire

FILE: hdl/gvzs_out_stage.sv
// Result register holding one victim report until transferred.
// Depends on gvzs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gvzs_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  gvzs_pkg::trk_ctl_t   ctl_i,
  input  gvzs_pkg::victim_t    result_i,
  output logic                 out_free_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output gvzs_pkg::victim_t    out_data_o
);
  import gvzs_pkg::*;

  logic    vld_q, vld_d;
  victim_t res_q;

  assign out_free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (ctl_i.emit) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Testbench for gc_victim_zone_selector_core: scans of zone statistics go in, and each
// victim result is checked against an in-bench tracker of the running best zone.
// Depends on gvzs_pkg and the selector RTL only.
`timescale 1ns / 1ps

module testbench;
  import gvzs_pkg::*;

  localparam int unsigned IDLE_PCT     = 36;
  localparam int unsigned RAND_ITEMS   = 650;
  localparam int unsigned NO_IDLE_RUN  = 150;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned STALL_LIMIT  = 2000;

  localparam logic [ModeW-1:0]  MODE_UNUSED = 2'd3;
  localparam logic [CountW-1:0] COUNT_MAX   = '1;
  localparam logic [CountW-1:0] ZONE_BLOCKS = 17'd65536;
  localparam logic [TsW-1:0]    TS_MAX      = '1;
  localparam logic [ZoneW-1:0]  ZONE_MAX    = '1;

  logic             clk_i     = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  zone_stat_t       in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  victim_t          out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [ModeW-1:0] cfg_data  = '0;

  logic gaps_on = 1'b1;
  int   errors  = 0;
  int   stall_cycles = 0;

  // running-best tracker, mirrors the block's scan state
  logic [ModeW-1:0]  sel_mode     = MODE_GREEDY;
  logic              run_valid    = 1'b0;
  logic [ZoneW-1:0]  run_zone     = '0;
  logic [KeyW-1:0]   run_key      = '0;
  logic [CountW-1:0] run_garbage  = '0;
  victim_t           victim_q[$];

  gc_victim_zone_selector_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin : check_victim
    victim_t want;
    if (rst_n && out_valid && out_ready) begin
      if (victim_q.size() == 0) begin
        errors++;
        $error("victim result with nothing expected: found %0d zone %0d blocks %0d",
               out_data.found, out_data.victim_zone, out_data.victim_blocks);
      end else begin
        want = victim_q.pop_front();
        if (out_data.found !== want.found) begin
          errors++;
          $error("found: expected %0d, actual %0d", want.found, out_data.found);
        end
        if (out_data.victim_zone !== want.victim_zone) begin
          errors++;
          $error("victim_zone: expected %0d, actual %0d",
                 want.victim_zone, out_data.victim_zone);
        end
        if (out_data.victim_blocks !== want.victim_blocks) begin
          errors++;
          $error("victim_blocks: expected %0d, actual %0d",
                 want.victim_blocks, out_data.victim_blocks);
        end
      end
    end
  end

  task automatic track_zone(input zone_stat_t z);
    logic [KeyW-1:0] key;
    logic            take;
    victim_t         v;
    if (z.zone_full) begin
      if (sel_mode == MODE_TS) begin
        key  = z.age_sum;
        take = !run_valid || key < run_key;
      end else if (sel_mode == MODE_HEAT) begin
        key  = KeyW'(z.before_count) + (KeyW'(z.after_count) << 1);
        take = !run_valid || key < run_key;
      end else begin
        // greedy, unused encoding included
        key  = KeyW'(z.gc_blocks);
        take = !run_valid || key > run_key;
      end
      if (take) begin
        run_valid   = 1'b1;
        run_zone    = z.zone_index;
        run_key     = key;
        run_garbage = z.gc_blocks;
      end
    end
    if (z.last_zone) begin
      v.found         = run_valid;
      v.victim_zone   = run_valid ? run_zone : '0;
      v.victim_blocks = run_valid ? run_garbage : '0;
      victim_q = {victim_q, v};
      run_valid   = 1'b0;
      run_zone    = '0;
      run_key     = '0;
      run_garbage = '0;
    end
  endtask

  task automatic send_zone(input zone_stat_t z);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= z;
    do @(posedge clk_i); while (!in_ready);
    track_zone(z);
  endtask

  // drop valid, wait out all pending victims, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [ModeW-1:0] m);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk_i); while (!cfg_ready);
    sel_mode = m;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic zone_stat_t mk_zone(input logic [ZoneW-1:0] zone, input logic full,
                                         input logic [CountW-1:0] garbage,
                                         input logic [TsW-1:0] ts,
                                         input logic [CountW-1:0] before_cnt,
                                         input logic [CountW-1:0] after_cnt,
                                         input logic last);
    zone_stat_t z;
    z.zone_index   = zone;
    z.zone_full    = full;
    z.gc_blocks    = garbage;
    z.age_sum      = ts;
    z.before_count = before_cnt;
    z.after_count  = after_cnt;
    z.last_zone    = last;
    return z;
  endfunction

  // half the counts are tiny so that ties happen often
  function automatic logic [CountW-1:0] rand_count();
    if ($urandom_range(0, 1) != 0) return CountW'($urandom_range(0, 7));
    return CountW'($urandom());
  endfunction

  function automatic zone_stat_t rand_zone(input int unsigned full_pct, input logic last);
    logic [TsW-1:0] ts;
    if ($urandom_range(0, 1) != 0) ts = TsW'($urandom_range(0, 7));
    else ts = TsW'({$urandom(), $urandom()});
    return mk_zone(ZoneW'($urandom()), $urandom_range(0, 99) < full_pct, rand_count(), ts,
                   rand_count(), rand_count(), last);
  endfunction

  task automatic test_greedy_extremes();
    // runs in the reset mode, no register write yet
    send_zone(mk_zone('0, 1'b1, '0, TS_MAX, COUNT_MAX, COUNT_MAX, 1'b0));
    send_zone(mk_zone(12'd5, 1'b0, COUNT_MAX, '0, '0, '0, 1'b0));
    send_zone(mk_zone(12'd7, 1'b1, '0, '0, '0, '0, 1'b0));
    // all-garbage zone wins and holds on a tie
    send_zone(mk_zone(ZONE_MAX, 1'b1, ZONE_BLOCKS, '0, '0, '0, 1'b0));
    send_zone(mk_zone(12'd9, 1'b1, ZONE_BLOCKS, '0, '0, '0, 1'b1));
    send_zone(mk_zone(12'd100, 1'b1, COUNT_MAX, '0, '0, '0, 1'b1));
  endtask

  task automatic test_no_victim();
    send_zone(mk_zone(12'd12, 1'b0, 17'd40, '0, '0, '0, 1'b0));
    send_zone(mk_zone(12'd13, 1'b0, 17'd41, '0, '0, '0, 1'b1));
    send_zone(mk_zone(ZONE_MAX, 1'b0, COUNT_MAX, TS_MAX, COUNT_MAX, COUNT_MAX, 1'b1));
  endtask

  task automatic test_ts_mode();
    drain();
    write_mode(MODE_TS);
    send_zone(mk_zone(12'd1, 1'b1, 17'd3, TS_MAX, '0, '0, 1'b0));
    send_zone(mk_zone(12'd2, 1'b1, 17'd4, TS_MAX, '0, '0, 1'b0));
    send_zone(mk_zone(12'd3, 1'b1, 17'd5, '0, '0, '0, 1'b0));
    send_zone(mk_zone(12'd4, 1'b1, 17'd6, '0, '0, '0, 1'b1));
  endtask

  task automatic test_heat_mode();
    drain();
    write_mode(MODE_HEAT);
    send_zone(mk_zone(12'd10, 1'b1, 17'd1, '0, COUNT_MAX, COUNT_MAX, 1'b0));
    send_zone(mk_zone(12'd11, 1'b1, 17'd2, '0, 17'd2, 17'd0, 1'b0));
    // after_count weighs double: same heat, earlier zone kept
    send_zone(mk_zone(12'd12, 1'b1, 17'd3, '0, 17'd0, 17'd1, 1'b0));
    send_zone(mk_zone(12'd13, 1'b0, 17'd4, '0, '0, '0, 1'b1));
  endtask

  task automatic test_unused_mode();
    drain();
    write_mode(MODE_UNUSED);
    send_zone(mk_zone(12'd20, 1'b1, 17'd3, 48'd1, 17'd9, 17'd9, 1'b0));
    send_zone(mk_zone(12'd21, 1'b1, 17'd9, 48'd9, 17'd1, 17'd1, 1'b0));
    send_zone(mk_zone(12'd22, 1'b1, 17'd9, 48'd0, 17'd0, 17'd0, 1'b1));
  endtask

  task automatic test_mode_change_mid_scan();
    drain();
    write_mode(MODE_GREEDY);
    send_zone(mk_zone(12'd30, 1'b1, 17'd50, 48'd1000, '0, '0, 1'b0));
    send_zone(mk_zone(12'd31, 1'b1, 17'd10, 48'd5000, '0, '0, 1'b0));
    // stored key is still the garbage count 50 when the ts rule takes over
    drain();
    write_mode(MODE_TS);
    send_zone(mk_zone(12'd32, 1'b1, 17'd7, 48'd40, '0, '0, 1'b0));
    send_zone(mk_zone(12'd33, 1'b1, 17'd8, 48'd45, '0, '0, 1'b1));
  endtask

  task automatic test_random_scans();
    int          sent;
    int          len;
    int unsigned full_pct;
    sent = 0;
    gaps_on = 1'b0;
    while (sent < RAND_ITEMS) begin
      if (sent >= NO_IDLE_RUN) gaps_on = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        drain();
        write_mode(ModeW'($urandom_range(0, 3)));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      // mostly well-filled scans, some with few or no full zones
      full_pct = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : $urandom_range(50, 95);
      for (int k = 0; k < len; k++) begin
        send_zone(rand_zone(full_pct, k == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    test_greedy_extremes();
    test_no_victim();
    test_ts_mode();
    test_heat_mode();
    test_unused_mode();
    test_mode_change_mid_scan();
    test_random_scans();
    drain();
    repeat (10) @(posedge clk_i);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

FILE: gc_victim_zone_selector_core.f
+incdir+hdl
hdl/gvzs_pkg.sv
hdl/gvzs_in_stage.sv
hdl/gvzs_best_tracker.sv
hdl/gvzs_out_stage.sv
hdl/gc_victim_zone_selector_core.sv
dv/testbench.sv
